FILE: src/vftq_pkg.sv
// ----------------------------------------------------------------------------
// vftq_pkg: shared types, constants and rounding helpers
// Fixed-point constants and helper functions of the from-to quaternion block.
// ----------------------------------------------------------------------------
package vftq_pkg;

	localparam int IN_FRAC_DEF  = 12;
	localparam int OUT_FRAC_DEF = 14;
	localparam int NORM_W       = 33;
	localparam int FIELD_W      = 16;

	localparam logic [30:0] THR_RESET = 31'd1073731086;

	localparam logic signed [63:0] ONE30 = 64'sh0000_0000_4000_0000;

	localparam logic [63:0] AXIS_MIN_SQ   = ((64'd1 << 60) + 64'd999) / 64'd1000;
	localparam logic [63:0] AXIS_NORM_MIN = (64'd1 << 60) / 64'd1000000;
	localparam logic [63:0] QUAT_MIN_SQ   = 64'd115292150;

	localparam logic [1:0] CASE_GENERAL  = 2'd0;
	localparam logic [1:0] CASE_ALIGNED  = 2'd1;
	localparam logic [1:0] CASE_OPPOSITE = 2'd2;

	typedef struct packed {
		logic en;
		logic valid;
	} vftq_ctl_t;

	// round to nearest, ties away from zero, then shift right
	function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
			input int unsigned s);
		logic [63:0] half;
		logic [63:0] mag;
		if (s == 0) return v;
		half = 64'd1 << (s - 1);
		if (!v[63]) return $signed((64'(v) + half) >> s);
		mag = 64'(-v);
		return -$signed((mag + half) >> s);
	endfunction

	// Q2.30 to output format, saturated, low 16 bits
	function automatic logic [FIELD_W-1:0] to_out(input logic signed [63:0] q,
			input int unsigned ofb);
		logic signed [63:0] r;
		logic signed [63:0] lim;
		r   = shr_round(q, 30 - ofb);
		lim = 64'sd1 <<< ofb;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[FIELD_W-1:0];
	endfunction

endpackage

FILE: src/vector_from_to_quaternion.sv
// ----------------------------------------------------------------------------
// vector_from_to_quaternion: shortest-arc rotation between two vectors
// Normalizes both vectors, classifies them by dot product and emits a unit
// quaternion in Q1.14 with a case code.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per vector pair (from x,y,z then to x,y,z, Q3.12).
//   m_* returns one word per pair: the quaternion x,y,z,w in m_tdata and the
//   case code (general, aligned, opposite) in m_tuser.
//   cfg_* writes the dot-product threshold (Q2.30); it is always ready and
//   is meant to be written while no pair is in flight.
//   Throughput: one pair per cycle while the output is not stalled, fully pipelined.
//   Two 70-stage normalizers (32-step square root, 32-step divider each)
//   lie on the path from acceptance to m_tvalid.
//   Reset clears all valid bits and reloads the threshold to about 0.99999.
//   When the receiver stalls, the output register holds its word and the
//   pipeline keeps moving until a word reaches the last stage; only then
//   are all stages frozen and s_tready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector_from_to_quaternion #(
	parameter int INPUT_FRAC_BITS  = vftq_pkg::IN_FRAC_DEF,
	parameter int OUTPUT_FRAC_BITS = vftq_pkg::OUT_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic [1:0]  m_tuser,   // case_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data   // parallel_threshold
);
	import vftq_pkg::*;

	localparam logic [63:0] IN_MIN_SQ =
		64'((64'd1 << (2 * INPUT_FRAC_BITS)) / 64'd1000000);
	localparam logic [15:0] IDENT_W = to_out(ONE30, OUTPUT_FRAC_BITS);

	// threshold register
	logic [30:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	// global advance: freeze only when the last stage and the output are both full and m_tready is low
	logic en;
	logic n2_valid;
	logic m_valid_q;

	assign en       = !n2_valid || !m_valid_q || m_tready;
	assign s_tready = en;

	// unit vectors from both inputs
	vftq_ctl_t            in_ctl;
	logic signed [NORM_W-1:0] f_in [3];
	logic signed [NORM_W-1:0] t_in [3];
	logic signed [NORM_W-1:0] f_no [3];
	logic signed [NORM_W-1:0] t_no [3];
	logic                 f_valid;
	logic                 f_ok;
	logic                 t_ok;

	assign in_ctl.en    = en;
	assign in_ctl.valid = s_tvalid;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			f_in[i] = NORM_W'($signed(s_tdata[16 * i +: 16]));
			t_in[i] = NORM_W'($signed(s_tdata[48 + 16 * i +: 16]));
		end
	end

	vftq_norm #(.N(3), .CW(NORM_W), .SW(1)) u_norm_from (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (in_ctl),
		.comp_in   (f_in),
		.min_sq    (IN_MIN_SQ),
		.sb_in     (1'b0),
		.valid_out (f_valid),
		.ok_out    (f_ok),
		.comp_out  (f_no),
		.sb_out    ()
	);

	vftq_norm #(.N(3), .CW(NORM_W), .SW(1)) u_norm_to (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (in_ctl),
		.comp_in   (t_in),
		.min_sq    (IN_MIN_SQ),
		.sb_in     (1'b0),
		.valid_out (),
		.ok_out    (t_ok),
		.comp_out  (t_no),
		.sb_out    ()
	);

	// short vectors fall back to (0,-1,0)
	logic signed [31:0] fu [3];
	logic signed [31:0] tu [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fu[i] = (i == 1) ? -32'sh4000_0000 : 32'sd0;
			tu[i] = (i == 1) ? -32'sh4000_0000 : 32'sd0;
			if (f_ok) fu[i] = f_no[i][31:0];
			if (t_ok) tu[i] = t_no[i][31:0];
		end
	end

	// products for dot, cross and the first-axis length
	logic               v_s1;
	logic signed [63:0] pd_s1 [3];
	logic signed [63:0] pc_s1 [6];
	logic [63:0]        fyy_s1;
	logic [63:0]        fzz_s1;
	logic signed [31:0] f_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= f_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) pd_s1[i] <= 64'(fu[i]) * 64'(tu[i]);
			pc_s1[0] <= 64'(fu[1]) * 64'(tu[2]);
			pc_s1[1] <= 64'(fu[2]) * 64'(tu[1]);
			pc_s1[2] <= 64'(fu[2]) * 64'(tu[0]);
			pc_s1[3] <= 64'(fu[0]) * 64'(tu[2]);
			pc_s1[4] <= 64'(fu[0]) * 64'(tu[1]);
			pc_s1[5] <= 64'(fu[1]) * 64'(tu[0]);
			fyy_s1   <= 64'(64'(fu[1]) * 64'(fu[1]));
			fzz_s1   <= 64'(64'(fu[2]) * 64'(fu[2]));
			f_s1     <= fu;
		end
	end

	// dot and cross back in Q2.30
	logic               v_s2;
	logic signed [63:0] dot_s2;
	logic signed [63:0] crs_s2 [3];
	logic [63:0]        a2_s2;
	logic signed [31:0] f_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2    <= shr_round(pd_s1[0] + pd_s1[1] + pd_s1[2], 30);
			crs_s2[0] <= shr_round(pc_s1[0] - pc_s1[1], 30);
			crs_s2[1] <= shr_round(pc_s1[2] - pc_s1[3], 30);
			crs_s2[2] <= shr_round(pc_s1[4] - pc_s1[5], 30);
			a2_s2     <= fyy_s1 + fzz_s1;
			f_s2      <= f_s1;
		end
	end

	// classify, then assemble the vector for the second normalizer
	logic                     v_s3;
	logic [1:0]               code_s3;
	logic signed [NORM_W-1:0] q_s3 [4];
	logic [63:0]              min_s3;
	logic signed [63:0]       thr_s;
	logic [1:0]               code_c;
	logic signed [NORM_W-1:0] q_c [4];
	logic [63:0]              min_c;

	assign thr_s = $signed({33'd0, thr_q});

	always_comb begin
		code_c = CASE_GENERAL;
		min_c  = QUAT_MIN_SQ;
		q_c[0] = NORM_W'(crs_s2[0]);
		q_c[1] = NORM_W'(crs_s2[1]);
		q_c[2] = NORM_W'(crs_s2[2]);
		q_c[3] = NORM_W'(ONE30 + dot_s2);
		if (dot_s2 >= thr_s) begin
			code_c = CASE_ALIGNED;
			for (int i = 0; i < 4; i++) q_c[i] = '0;
		end else if (dot_s2 <= -thr_s) begin
			code_c = CASE_OPPOSITE;
			min_c  = AXIS_NORM_MIN;
			q_c[3] = '0;
			// first axis too short: cross with Y instead of X
			if (a2_s2 < AXIS_MIN_SQ) begin
				q_c[0] = -NORM_W'(f_s2[2]);
				q_c[1] = '0;
				q_c[2] = NORM_W'(f_s2[0]);
			end else begin
				q_c[0] = '0;
				q_c[1] = NORM_W'(f_s2[2]);
				q_c[2] = -NORM_W'(f_s2[1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s3 <= code_c;
			q_s3    <= q_c;
			min_s3  <= min_c;
		end
	end

	// quaternion or half-turn axis normalizer
	vftq_ctl_t                n2_ctl;
	logic signed [NORM_W-1:0] q_no [4];
	logic                     q_ok;
	logic [1:0]               code_n2;

	assign n2_ctl.en    = en;
	assign n2_ctl.valid = v_s3;

	vftq_norm #(.N(4), .CW(NORM_W), .SW(2)) u_norm_quat (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (n2_ctl),
		.comp_in   (q_s3),
		.min_sq    (min_s3),
		.sb_in     (code_s3),
		.valid_out (n2_valid),
		.ok_out    (q_ok),
		.comp_out  (q_no),
		.sb_out    (code_n2)
	);

	// final selection and output rounding
	logic signed [63:0] qf [4];
	logic [63:0]        data_c;

	always_comb begin
		for (int i = 0; i < 4; i++) qf[i] = 64'(q_no[i]);
		case (code_n2)
			CASE_ALIGNED: begin
				qf[0] = '0;
				qf[1] = '0;
				qf[2] = '0;
				qf[3] = ONE30;
			end
			CASE_OPPOSITE: begin
				// a degenerate axis points down
				if (!q_ok) begin
					qf[0] = '0;
					qf[1] = -ONE30;
					qf[2] = '0;
				end
				qf[3] = '0;
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 4; i++) data_c[16 * i +: 16] = to_out(qf[i], OUTPUT_FRAC_BITS);
	end

	// output register: hold while the receiver stalls
	logic [63:0] m_data_q;
	logic [1:0]  m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (!m_valid_q || m_tready) m_valid_q <= n2_valid;
	end

	always_ff @(posedge clk) begin
		if ((!m_valid_q || m_tready) && n2_valid) begin
			m_data_q <= data_c;
			m_user_q <= code_n2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef NO_ASSERTIONS
	a_code_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == CASE_GENERAL || m_tuser == CASE_ALIGNED ||
			m_tuser == CASE_OPPOSITE))
		else $error("unknown case code on output");

	a_aligned_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == CASE_ALIGNED) |->
			(m_tdata[47:0] == 48'd0 && m_tdata[63:48] == IDENT_W))
		else $error("aligned word is not the identity");

	a_opposite_w: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == CASE_OPPOSITE) |-> m_tdata[63:48] == 16'd0)
		else $error("half-turn word has non-zero w");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input blocked without an output stall");
`endif
endmodule

FILE: src/vftq_delay.sv
// ----------------------------------------------------------------------------
// vftq_delay: stallable delay line
// Carries side data and valid bits alongside a pipelined arithmetic unit.
// ----------------------------------------------------------------------------
module vftq_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_s [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_tap
		logic [W-1:0] tap_in;
		if (k == 0) begin : g_first
			assign tap_in = d;
		end else begin : g_next
			assign tap_in = line_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				line_s[k] <= '0;
			end else if (en) begin
				line_s[k] <= tap_in;
			end
		end
	end

	assign q = line_s[DEPTH-1];
endmodule

FILE: src/vftq_isqrt.sv
// ----------------------------------------------------------------------------
// vftq_isqrt: pipelined integer square root
// Floor square root of a 64-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module vftq_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	logic [63:0] rem_s [32];
	logic [63:0] res_s [32];

	for (genvar k = 0; k < 32; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rem_in;
		logic [63:0] res_in;
		logic [63:0] trial;
		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[31][31:0];
endmodule

FILE: src/vftq_div.sv
// ----------------------------------------------------------------------------
// vftq_div: pipelined restoring divider
// 64-bit dividend over 32-bit divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vftq_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);
	logic [63:0] rem_s [32];
	logic [31:0] den_s [32];
	logic [31:0] quo_s [32];

	for (genvar j = 0; j < 32; j++) begin : g_step
		logic [63:0] rem_in;
		logic [31:0] den_in;
		logic [31:0] quo_in;
		logic [63:0] trial;
		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end
		assign trial = 64'(den_in) << (31 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_in;
				if (rem_in >= trial) begin
					rem_s[j] <= rem_in - trial;
					quo_s[j] <= quo_in | (32'd1 << (31 - j));
				end else begin
					rem_s[j] <= rem_in;
					quo_s[j] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[31];
endmodule

FILE: src/vftq_norm.sv
// ----------------------------------------------------------------------------
// vftq_norm: pipelined vector normalizer
// Scales a vector to unit length in Q2.30; flags vectors that are too short.
// ----------------------------------------------------------------------------
module vftq_norm #(
	parameter int N  = 3,
	parameter int CW = vftq_pkg::NORM_W,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vftq_pkg::vftq_ctl_t  ctl,
	input  logic signed [CW-1:0] comp_in [N],
	input  logic [63:0]          min_sq,
	input  logic [SW-1:0]        sb_in,
	output logic                 valid_out,
	output logic                 ok_out,
	output logic signed [CW-1:0] comp_out [N],
	output logic [SW-1:0]        sb_out
);
	import vftq_pkg::*;

	localparam int PW  = 2 * CW;
	localparam int W1  = 8 + N * CW + SW;
	localparam int W2  = 2 + N + N * CW + SW;

	// squares
	logic                 v_s1;
	logic [PW-1:0]        sqr_s1 [N];
	logic signed [CW-1:0] comp_s1 [N];
	logic [63:0]          min_s1;
	logic [SW-1:0]        sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ctl.en) v_s1 <= ctl.valid;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < N; i++) begin
				sqr_s1[i]  <= PW'(PW'(comp_in[i]) * PW'(comp_in[i]));
				comp_s1[i] <= comp_in[i];
			end
			min_s1 <= min_sq;
			sb_s1  <= sb_in;
		end
	end

	// squared length and short-vector test
	logic                 v_s2;
	logic                 ok_s2;
	logic [63:0]          sq_s2;
	logic signed [CW-1:0] comp_s2 [N];
	logic [SW-1:0]        sb_s2;
	logic [63:0]          sum_c;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < N; i++) sum_c = sum_c + 64'(sqr_s1[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ctl.en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sq_s2   <= sum_c;
			ok_s2   <= sum_c > min_s1;
			comp_s2 <= comp_s1;
			sb_s2   <= sb_s1;
		end
	end

	// scale by powers of four into [2^60, 2^63), coarse steps
	logic                 v_s3;
	logic                 ok_s3;
	logic [63:0]          sq_s3;
	logic [5:0]           sh_s3;
	logic signed [CW-1:0] comp_s3 [N];
	logic [SW-1:0]        sb_s3;
	logic [63:0]          sa3;
	logic [5:0]           sha3;

	always_comb begin
		sa3  = sq_s2;
		sha3 = '0;
		if (sa3 < (64'd1 << 28)) begin sa3 = sa3 << 32; sha3 = sha3 + 6'd16; end
		if (sa3 < (64'd1 << 44)) begin sa3 = sa3 << 16; sha3 = sha3 + 6'd8;  end
		if (sa3 < (64'd1 << 52)) begin sa3 = sa3 << 8;  sha3 = sha3 + 6'd4;  end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (ctl.en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sq_s3   <= sa3;
			sh_s3   <= sha3;
			ok_s3   <= ok_s2;
			comp_s3 <= comp_s2;
			sb_s3   <= sb_s2;
		end
	end

	// fine steps
	logic                 v_s4;
	logic                 ok_s4;
	logic [63:0]          sq_s4;
	logic [5:0]           sh_s4;
	logic signed [CW-1:0] comp_s4 [N];
	logic [SW-1:0]        sb_s4;
	logic [63:0]          sa4;
	logic [5:0]           sha4;

	always_comb begin
		sa4  = sq_s3;
		sha4 = sh_s3;
		if (sa4 < (64'd1 << 56)) begin sa4 = sa4 << 4; sha4 = sha4 + 6'd2; end
		if (sa4 < (64'd1 << 58)) begin sa4 = sa4 << 2; sha4 = sha4 + 6'd1; end
		if (sa4 < (64'd1 << 60)) begin sa4 = sa4 << 2; sha4 = sha4 + 6'd1; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (ctl.en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sq_s4   <= sa4;
			sh_s4   <= sha4;
			ok_s4   <= ok_s3;
			comp_s4 <= comp_s3;
			sb_s4   <= sb_s3;
		end
	end

	// square root, side data alongside
	logic [31:0]   root;
	logic [W1-1:0] d1;
	logic [W1-1:0] q1;

	vftq_isqrt u_isqrt (
		.clk  (clk),
		.en   (ctl.en),
		.rad  (sq_s4),
		.root (root)
	);

	always_comb begin
		d1      = '0;
		d1[0]   = v_s4;
		d1[1]   = ok_s4;
		d1[7:2] = sh_s4;
		for (int i = 0; i < N; i++) d1[8 + i * CW +: CW] = comp_s4[i];
		d1[8 + N * CW +: SW] = sb_s4;
	end

	vftq_delay #(.W(W1), .DEPTH(32)) u_dly_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (ctl.en),
		.d      (d1),
		.q      (q1)
	);

	// dividends: |c| * 2^(s+30) plus half the root for rounding
	logic                 v_s5;
	logic                 ok_s5;
	logic [N-1:0]         neg_s5;
	logic [63:0]          num_s5 [N];
	logic [31:0]          den_s5;
	logic signed [CW-1:0] comp_s5 [N];
	logic [SW-1:0]        sb_s5;
	logic signed [CW-1:0] comp_d1 [N];
	logic [CW-1:0]        absc [N];
	logic [6:0]           shift_d1;

	always_comb begin
		shift_d1 = 7'(q1[7:2]) + 7'd30;
		for (int i = 0; i < N; i++) begin
			comp_d1[i] = q1[8 + i * CW +: CW];
			absc[i]    = comp_d1[i][CW-1] ? CW'(-comp_d1[i]) : CW'(comp_d1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (ctl.en) v_s5 <= q1[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			ok_s5  <= q1[1];
			den_s5 <= root;
			sb_s5  <= q1[8 + N * CW +: SW];
			for (int i = 0; i < N; i++) begin
				num_s5[i]  <= (64'(absc[i]) << shift_d1) + 64'(root >> 1);
				neg_s5[i]  <= comp_d1[i][CW-1];
				comp_s5[i] <= comp_d1[i];
			end
		end
	end

	// one divider lane per component
	logic [31:0]   quo [N];
	logic [W2-1:0] d2;
	logic [W2-1:0] q2;

	for (genvar i = 0; i < N; i++) begin : g_lane
		vftq_div u_div (
			.clk (clk),
			.en  (ctl.en),
			.num (num_s5[i]),
			.den (den_s5),
			.quo (quo[i])
		);
	end

	always_comb begin
		d2            = '0;
		d2[0]         = v_s5;
		d2[1]         = ok_s5;
		d2[2 +: N]    = neg_s5;
		for (int i = 0; i < N; i++) d2[2 + N + i * CW +: CW] = comp_s5[i];
		d2[2 + N + N * CW +: SW] = sb_s5;
	end

	vftq_delay #(.W(W2), .DEPTH(32)) u_dly_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (ctl.en),
		.d      (d2),
		.q      (q2)
	);

	// sign, saturate, and keep the input where the vector was too short
	logic signed [63:0] val [N];
	logic [N-1:0]       neg_d2;

	always_comb begin
		neg_d2 = q2[2 +: N];
		for (int i = 0; i < N; i++) begin
			val[i] = neg_d2[i] ? -$signed({32'd0, quo[i]}) : $signed({32'd0, quo[i]});
			if (val[i] > ONE30) val[i] = ONE30;
			if (val[i] < -ONE30) val[i] = -ONE30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (ctl.en) valid_out <= q2[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			ok_out <= q2[1];
			sb_out <= q2[2 + N + N * CW +: SW];
			for (int i = 0; i < N; i++) begin
				comp_out[i] <= q2[1] ? CW'(val[i]) : q2[2 + N + i * CW +: CW];
			end
		end
	end
endmodule
